### src/drt_pkg.sv
package drt_pkg;

  // Capacity of the region list.
  localparam int MAX_REGIONS = 8;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

  localparam int COORD_W     = 12;
  localparam int IN_COORD_W  = 16;
  localparam int BOX_W       = 4 * COORD_W;
  localparam int IN_DATA_W   = 4 * IN_COORD_W;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COORD_W-1:0] SCREEN_W_RST = COORD_W'(480);
  localparam logic [COORD_W-1:0] SCREEN_H_RST = COORD_W'(320);

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = CFG_IDX_W'(1);

  typedef logic [COORD_W-1:0] coord_t;

  // Packed with x in the lowest bits, as on the stream ports.
  typedef struct packed {
    coord_t h;
    coord_t w;
    coord_t y;
    coord_t x;
  } box_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_FULL  = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_TEST,
    ST_MERGE,
    ST_MVWR,
    ST_RD,
    ST_FINISH,
    ST_DRAIN,
    ST_DEMPTY
  } state_t;

endpackage

### src/drt_ram.sv
module drt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/dirty_rectangle_tracker_top.sv
// Dirty rectangle tracker. Keeps up to MAX_REGIONS screen regions in a small RAM.
// in_tready is high only while the block is idle. An add passes through the accept
// step, a clamp step, a test step for each stored region it scans, a merge step for
// each region it overlaps, a move-write and a re-read for every region removed by a
// merge (only the move-write when the removed region is the last entry) and, unless
// the clamped rectangle is empty, a final write of the result. The scan is set by
// the single read port of the region RAM.
// Mark-full and clear leave the block idle.
// A drain emits one region per cycle while out_tready stays high; a drain
// of an empty list emits a single transaction with out_tuser and out_tlast set
// and zero data. The output register lets a finished result wait while the next
// transaction is accepted.
module dirty_rectangle_tracker_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [drt_pkg::IN_DATA_W-1:0]     in_tdata,  // rect_x, rect_y, rect_w, rect_h
  input  logic [drt_pkg::ACT_W-1:0]         in_tuser,  // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [drt_pkg::BOX_W-1:0]         out_tdata, // region_x, region_y, region_w, region_h
  output logic                              out_tlast,
  output logic [0:0]                        out_tuser, // empty_res
  input  logic                              cfg_we,
  input  logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [drt_pkg::COORD_W-1:0]       cfg_data
);

  localparam int IW = drt_pkg::IN_COORD_W;
  localparam int CW = drt_pkg::COORD_W;

  function automatic logic box_touch(drt_pkg::box_t a, drt_pkg::box_t b);
    logic tx;
    logic ty;
    tx = ({1'b0, a.x} < ({1'b0, b.x} + {1'b0, b.w})) &&
         (({1'b0, a.x} + {1'b0, a.w}) > {1'b0, b.x});
    ty = ({1'b0, a.y} < ({1'b0, b.y} + {1'b0, b.h})) &&
         (({1'b0, a.y} + {1'b0, a.h}) > {1'b0, b.y});
    return tx && ty;
  endfunction

  // Bounding box of two regions, right and bottom edges clamped to the screen.
  function automatic drt_pkg::box_t box_merge(drt_pkg::box_t a, drt_pkg::box_t b,
                                              drt_pkg::coord_t sw, drt_pkg::coord_t sh);
    logic [CW:0]     ax2;
    logic [CW:0]     bx2;
    logic [CW:0]     ay2;
    logic [CW:0]     by2;
    logic [CW:0]     x2;
    logic [CW:0]     y2;
    drt_pkg::box_t   o;
    ax2 = {1'b0, a.x} + {1'b0, a.w};
    bx2 = {1'b0, b.x} + {1'b0, b.w};
    ay2 = {1'b0, a.y} + {1'b0, a.h};
    by2 = {1'b0, b.y} + {1'b0, b.h};
    x2  = (ax2 > bx2) ? ax2 : bx2;
    y2  = (ay2 > by2) ? ay2 : by2;
    o.x = (a.x < b.x) ? a.x : b.x;
    o.y = (a.y < b.y) ? a.y : b.y;
    o.w = (x2 > {1'b0, sw}) ? (sw - o.x) : CW'(x2 - {1'b0, o.x});
    o.h = (y2 > {1'b0, sh}) ? (sh - o.y) : CW'(y2 - {1'b0, o.y});
    return o;
  endfunction

  drt_pkg::state_t                 state_r, state_nxt;
  logic [drt_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [drt_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [drt_pkg::IDX_W-1:0]       tgt_idx_r, tgt_idx_nxt;
  logic                            merged_r, merged_nxt;
  drt_pkg::box_t                   rect_r, rect_nxt;
  drt_pkg::box_t                   tgt_r, tgt_nxt;
  drt_pkg::box_t                   cur_r, cur_nxt;
  logic [drt_pkg::IN_DATA_W-1:0]   in_data_r, in_data_nxt;
  drt_pkg::coord_t                 sw_r, sh_r;

  logic                            out_valid_r, out_valid_nxt;
  drt_pkg::box_t                   out_box_r, out_box_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_empty_r, out_empty_nxt;

  logic                            ram_we;
  logic [drt_pkg::IDX_W-1:0]       ram_waddr;
  drt_pkg::box_t                   ram_wdata;
  logic [drt_pkg::IDX_W-1:0]       ram_raddr;
  drt_pkg::box_t                   ram_rdata;

  drt_ram #(
    .WIDTH (drt_pkg::BOX_W),
    .DEPTH (drt_pkg::MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= drt_pkg::SCREEN_W_RST;
      sh_r <= drt_pkg::SCREEN_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drt_pkg::REG_SCREEN_W: sw_r <= cfg_data;
        drt_pkg::REG_SCREEN_H: sh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    tgt_idx_r   <= tgt_idx_nxt;
    merged_r    <= merged_nxt;
    rect_r      <= rect_nxt;
    tgt_r       <= tgt_nxt;
    cur_r       <= cur_nxt;
    in_data_r   <= in_data_nxt;
    out_box_r   <= out_box_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  always_comb begin
    logic signed [IW+1:0]       cx, cy, cwi, chi, sx, sy, cw, ch, swe, she;
    logic [IW-1:0]              ix, iy, iw, ih;
    logic                       out_free;
    logic [drt_pkg::CNT_W-1:0]  idx_inc;
    logic [drt_pkg::CNT_W-1:0]  cnt_dec;
    drt_pkg::box_t              full_box;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    tgt_idx_nxt   = tgt_idx_r;
    merged_nxt    = merged_r;
    rect_nxt      = rect_r;
    tgt_nxt       = tgt_r;
    cur_nxt       = cur_r;
    in_data_nxt   = in_data_r;
    out_box_nxt   = out_box_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = rect_r;
    in_tready     = 1'b0;

    out_free      = !out_valid_r || out_tready;
    out_valid_nxt = out_valid_r && !out_tready;
    idx_inc       = drt_pkg::CNT_W'(idx_r) + drt_pkg::CNT_W'(1);
    cnt_dec       = cnt_r - drt_pkg::CNT_W'(1);
    full_box      = '{x: '0, y: '0, w: sw_r, h: sh_r};

    // Input clamp: corners below zero go to zero, size kept; far edges clip to screen.
    ix  = in_data_r[IW-1:0];
    iy  = in_data_r[2*IW-1:IW];
    iw  = in_data_r[3*IW-1:2*IW];
    ih  = in_data_r[4*IW-1:3*IW];
    cx  = ix[IW-1] ? '0 : {2'b00, ix};
    cy  = iy[IW-1] ? '0 : {2'b00, iy};
    cwi = {{2{iw[IW-1]}}, iw};
    chi = {{2{ih[IW-1]}}, ih};
    swe = {{(IW+2-CW){1'b0}}, sw_r};
    she = {{(IW+2-CW){1'b0}}, sh_r};
    sx  = cx + cwi;
    sy  = cy + chi;
    cw  = (sx > swe) ? (swe - cx) : cwi;
    ch  = (sy > she) ? (she - cy) : chi;

    unique case (state_r)
      drt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          in_data_nxt = in_tdata;
          idx_nxt     = '0;
          merged_nxt  = 1'b0;
          unique case (drt_pkg::act_t'(in_tuser))
            drt_pkg::ACT_ADD: state_nxt = drt_pkg::ST_CLAMP;
            drt_pkg::ACT_FULL: begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = full_box;
              cnt_nxt   = drt_pkg::CNT_W'(1);
            end
            drt_pkg::ACT_DRAIN: begin
              state_nxt = (cnt_r == '0) ? drt_pkg::ST_DEMPTY : drt_pkg::ST_DRAIN;
            end
            drt_pkg::ACT_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end

      drt_pkg::ST_CLAMP: begin
        rect_nxt = '{x: cx[CW-1:0], y: cy[CW-1:0], w: cw[CW-1:0], h: ch[CW-1:0]};
        if (cw <= 0 || ch <= 0) begin
          state_nxt = drt_pkg::ST_IDLE;
        end else if (cnt_r == '0) begin
          state_nxt = drt_pkg::ST_FINISH;
        end else begin
          state_nxt = drt_pkg::ST_TEST;
        end
      end

      // The RAM output holds entry idx_r here.
      drt_pkg::ST_TEST: begin
        cur_nxt = ram_rdata;
        if (box_touch(rect_r, ram_rdata)) begin
          state_nxt = drt_pkg::ST_MERGE;
        end else if (idx_inc < cnt_r) begin
          idx_nxt   = drt_pkg::IDX_W'(idx_inc);
          state_nxt = drt_pkg::ST_TEST;
        end else begin
          state_nxt = drt_pkg::ST_FINISH;
        end
      end

      drt_pkg::ST_MERGE: begin
        tgt_nxt = box_merge(merged_r ? tgt_r : rect_r, cur_r, sw_r, sh_r);
        if (!merged_r) begin
          merged_nxt  = 1'b1;
          tgt_idx_nxt = idx_r;
          if (idx_inc < cnt_r) begin
            idx_nxt   = drt_pkg::IDX_W'(idx_inc);
            state_nxt = drt_pkg::ST_TEST;
          end else begin
            state_nxt = drt_pkg::ST_FINISH;
          end
        end else begin
          // Fetch the last entry to fill the slot that this merge frees.
          state_nxt = drt_pkg::ST_MVWR;
        end
      end

      drt_pkg::ST_MVWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        cnt_nxt   = cnt_dec;
        state_nxt = (drt_pkg::CNT_W'(idx_r) < cnt_dec) ? drt_pkg::ST_RD
                                                       : drt_pkg::ST_FINISH;
      end

      // Re-read the slot that just received the moved entry.
      drt_pkg::ST_RD: begin
        state_nxt = drt_pkg::ST_TEST;
      end

      drt_pkg::ST_FINISH: begin
        ram_we    = 1'b1;
        state_nxt = drt_pkg::ST_IDLE;
        if (merged_r) begin
          ram_waddr = tgt_idx_r;
          ram_wdata = tgt_r;
        end else if (cnt_r < drt_pkg::CNT_W'(drt_pkg::MAX_REGIONS)) begin
          ram_waddr = drt_pkg::IDX_W'(cnt_r);
          ram_wdata = rect_r;
          cnt_nxt   = cnt_r + drt_pkg::CNT_W'(1);
        end else begin
          ram_waddr = '0;
          ram_wdata = full_box;
          cnt_nxt   = drt_pkg::CNT_W'(1);
        end
      end

      drt_pkg::ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_box_nxt   = ram_rdata;
          out_empty_nxt = 1'b0;
          out_last_nxt  = (idx_inc == cnt_r);
          if (idx_inc == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = drt_pkg::ST_IDLE;
          end else begin
            idx_nxt = drt_pkg::IDX_W'(idx_inc);
          end
        end
      end

      drt_pkg::ST_DEMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_box_nxt   = '0;
          out_empty_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = drt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = drt_pkg::ST_IDLE;
    endcase

    // The merge step swaps in the last entry; everything else reads ahead at idx_nxt.
    if (state_r == drt_pkg::ST_MERGE && merged_r) begin
      ram_raddr = drt_pkg::IDX_W'(cnt_dec);
    end else begin
      ram_raddr = idx_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_box_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule

### src/drt_checker.sv
module drt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [drt_pkg::ACT_W-1:0]     in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [drt_pkg::BOX_W-1:0]     out_tdata,
  input logic                          out_tlast,
  input logic [0:0]                    out_tuser
);

  // An empty drain result is a single, all-zero transaction.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == '0)
    else $error("empty drain result without last or with nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // An add always passes through the clamp state, so the input closes after it.
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == drt_pkg::ACT_ADD |=> !in_tready)
    else $error("input ready right after an add");

  // While a region other than the last of a drain waits, no new transaction is taken.
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a drain");

endmodule

bind dirty_rectangle_tracker_top drt_checker u_drt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
